// ===== rtl/irpd_pkg.sv =====
// Shared constants and types of the pulse-distance infrared frame decoder.
package irpd_pkg;

    localparam int MAX_DATA_BITS_DEF = 32;

    localparam int DUR_W      = 16;
    localparam int TOL_W      = 6;
    localparam int EXC_W      = 9;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;
    localparam int BOUND_W    = 17;
    localparam int NUM_WIN    = 6;
    localparam int WIN_W      = 3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WIDE_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_EXCESS    = 2'd2;

    // result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_MISMATCH = 2'd1;
    localparam logic [1:0] ST_EARLY    = 2'd2;

    // window slots
    localparam logic [WIN_W-1:0] WIN_HDR_MARK = 3'd0;
    localparam logic [WIN_W-1:0] WIN_HDR_SPC  = 3'd1;
    localparam logic [WIN_W-1:0] WIN_BIT_MARK = 3'd2;
    localparam logic [WIN_W-1:0] WIN_ONE_SPC  = 3'd3;
    localparam logic [WIN_W-1:0] WIN_ZERO_SPC = 3'd4;
    localparam logic [WIN_W-1:0] WIN_GAP_SPC  = 3'd5;

    // nominal timings, microseconds
    localparam logic [DUR_W-1:0] T_HDR_MARK_N = 16'd8000;
    localparam logic [DUR_W-1:0] T_HDR_SPC_N  = 16'd4000;
    localparam logic [DUR_W-1:0] T_GAP_N      = 16'd60000;
    localparam logic [DUR_W-1:0] T_HDR_W      = 16'd4500;
    localparam logic [DUR_W-1:0] T_GAP_W      = 16'd44000;
    localparam logic [DUR_W-1:0] T_BIT_MARK   = 16'd600;
    localparam logic [DUR_W-1:0] T_ONE_SPC    = 16'd1600;
    localparam logic [DUR_W-1:0] T_ZERO_SPC   = 16'd550;

    localparam logic [5:0] NARROW_BITS = 6'd28;
    localparam int         ADDR_SHIFT  = 12;

    // floor(x/100) for x < 2^24: (x * 167772) >> 24 is exact or one low
    localparam logic [17:0] DIV100_MUL   = 18'd167772;
    localparam int          DIV100_SHIFT = 24;

    typedef logic [NUM_WIN-1:0][BOUND_W-1:0] bound_vec_t;

    typedef struct packed {
        logic             restart;
        logic             wide;
        logic [TOL_W-1:0] tol;
        logic [EXC_W-1:0] excess;
    } win_cfg_t;

endpackage

// ===== rtl/irpd_win_calc.sv =====
// Match window bound calculator: one shared multiply pipeline swept over all windows.
module irpd_win_calc (
    input  logic                clk,
    input  logic                rst_n,
    input  irpd_pkg::win_cfg_t  cfg,
    output logic                busy,
    output irpd_pkg::bound_vec_t lo,
    output irpd_pkg::bound_vec_t hi
);
    import irpd_pkg::*;

    localparam int SEQ_LEN = 2 * NUM_WIN;
    localparam int SEQ_W   = $clog2(SEQ_LEN);
    localparam int PROD_W  = 24;
    localparam int MUL_W   = PROD_W + 18;

    logic              issue_on_reg, issue_on_next;
    logic [SEQ_W-1:0]  seq_reg, seq_next;

    logic              a_valid_reg;
    logic [SEQ_W-1:0]  a_idx_reg;
    logic [PROD_W-1:0] a_prod_reg;

    logic              b_valid_reg;
    logic [SEQ_W-1:0]  b_idx_reg;
    logic [PROD_W-1:0] b_prod_reg;
    logic [BOUND_W-1:0] b_q0_reg;

    bound_vec_t lo_reg, hi_reg;

    logic [WIN_W-1:0]  a_win;
    logic [DUR_W-1:0]  base;
    logic [DUR_W-1:0]  expect_us;
    logic [7:0]        factor;
    logic [PROD_W-1:0] prod;
    logic [MUL_W-1:0]  recip_prod;
    logic [PROD_W-1:0] rem;
    logic [BOUND_W-1:0] quot;
    logic [BOUND_W-1:0] bound;
    logic [WIN_W-1:0]  c_win;

    // sweep control: a write restarts the sweep from slot zero
    always_comb
    begin
        issue_on_next = issue_on_reg;
        seq_next      = seq_reg;
        if (cfg.restart)
        begin
            issue_on_next = 1'b1;
            seq_next      = '0;
        end
        else if (issue_on_reg)
        begin
            if (seq_reg == SEQ_W'(SEQ_LEN - 1))
                issue_on_next = 1'b0;
            else
                seq_next = seq_reg + 1'b1;
        end
    end

    // stage A: expected duration and tolerance factor, one product
    assign a_win = seq_reg[SEQ_W-1:1];

    always_comb
    begin
        case (a_win)
            WIN_HDR_MARK: base = cfg.wide ? T_HDR_W : T_HDR_MARK_N;
            WIN_HDR_SPC:  base = cfg.wide ? T_HDR_W : T_HDR_SPC_N;
            WIN_BIT_MARK: base = T_BIT_MARK;
            WIN_ONE_SPC:  base = T_ONE_SPC;
            WIN_ZERO_SPC: base = T_ZERO_SPC;
            WIN_GAP_SPC:  base = cfg.wide ? T_GAP_W : T_GAP_N;
            default:      base = '0;
        endcase

        if (a_win == WIN_HDR_MARK || a_win == WIN_BIT_MARK)
            expect_us = base + DUR_W'(cfg.excess);
        else if (DUR_W'(cfg.excess) > base)
            expect_us = '0;   // excess larger than the space itself
        else
            expect_us = base - DUR_W'(cfg.excess);

        factor = seq_reg[0] ? (8'd100 + 8'(cfg.tol)) : (8'd100 - 8'(cfg.tol));
    end

    assign prod = PROD_W'(expect_us) * PROD_W'(factor);

    // stage B: reciprocal estimate of product / 100
    assign recip_prod = MUL_W'(a_prod_reg) * MUL_W'(DIV100_MUL);

    // stage C: one correction step, plus one on the upper bound
    assign rem   = b_prod_reg - (PROD_W'(b_q0_reg) * PROD_W'(100));
    assign quot  = b_q0_reg + BOUND_W'(rem >= PROD_W'(100));
    assign bound = b_idx_reg[0] ? (quot + 1'b1) : quot;
    assign c_win = b_idx_reg[SEQ_W-1:1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_on_reg <= 1'b1;
            seq_reg      <= '0;
            a_valid_reg  <= 1'b0;
            b_valid_reg  <= 1'b0;
        end
        else
        begin
            issue_on_reg <= issue_on_next;
            seq_reg      <= seq_next;
            a_valid_reg  <= issue_on_reg && !cfg.restart;
            b_valid_reg  <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_idx_reg  <= seq_reg;
        a_prod_reg <= prod;
        b_idx_reg  <= a_idx_reg;
        b_prod_reg <= a_prod_reg;
        b_q0_reg   <= recip_prod[DIV100_SHIFT +: BOUND_W];
        if (b_valid_reg)
        begin
            if (b_idx_reg[0])
                hi_reg[c_win] <= bound;
            else
                lo_reg[c_win] <= bound;
        end
    end

    assign busy = issue_on_reg || a_valid_reg || b_valid_reg;
    assign lo   = lo_reg;
    assign hi   = hi_reg;

endmodule

// ===== rtl/ir_pulse_distance_frame_decoder_unit.sv =====
// Top level of the pulse-distance infrared frame decoder.
//
// Input stream (s_axis): one measured mark or space duration per transfer,
// alternating mark and space from the first duration after the leading gap.
// tuser flags a frame start, tlast flags the last duration of a capture.
// Output stream (m_axis): one result per finished, failed or cut-off frame;
// tuser carries the status, tdata the bit count, value, address and command.
// Config port: cfg_we/cfg_index/cfg_data write wide_mode, tolerance_percent
// and mark_excess_us; write only while no frame is in flight.
//
// Data path: a duration is held in the input register, is checked against
// six precomputed windows and lands in the result register, which drives
// m_axis. Throughput: one duration per cycle while results are taken and
// no sweep runs, set by the window compares.
// Window bounds come from a shared multiply pipeline sweep over 12 slots;
// it runs after reset and after every config write, and s_axis_tready
// stays low for its length.
// Reset clears the frame state to idle, loads the default registers and
// starts the sweep. When the receiver stalls, the result register holds and
// the input register still takes one duration; after that s_axis_tready
// falls until the result is taken.
module ir_pulse_distance_frame_decoder_unit #(
    parameter int MAX_DATA_BITS = irpd_pkg::MAX_DATA_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    // config write port
    input  logic                              cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [irpd_pkg::CFG_DATA_W-1:0]   cfg_data,
    // duration stream
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [15:0]                       s_axis_tdata,  // [15:0] duration_us
    input  logic                              s_axis_tuser,  // [0] frame_start
    input  logic                              s_axis_tlast,  // capture_end
    // result stream
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // [5:0] bit_count, [37:6] frame_value, [57:38] address, [65:58] command,
    // [71:66] zero
    output logic [71:0]                       m_axis_tdata,
    output logic [1:0]                        m_axis_tuser   // [1:0] status
);
    import irpd_pkg::*;

    localparam logic [5:0] WIDE_BITS = 6'(MAX_DATA_BITS);

    // frame phases
    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_HDR_MARK = 3'd1;
    localparam logic [2:0] PH_HDR_SPC  = 3'd2;
    localparam logic [2:0] PH_BIT_MARK = 3'd3;
    localparam logic [2:0] PH_BIT_SPC  = 3'd4;
    localparam logic [2:0] PH_FT_MARK  = 3'd5;
    localparam logic [2:0] PH_FT_GAP   = 3'd6;
    localparam logic [2:0] PH_FT_HDR   = 3'd7;

    // config registers
    logic             wide_reg;
    logic [TOL_W-1:0] tol_reg;
    logic [EXC_W-1:0] excess_reg;

    // window bounds
    win_cfg_t   win_cfg;
    logic       win_busy;
    bound_vec_t win_lo, win_hi;
    logic [NUM_WIN-1:0] hit;

    // input register
    logic             in_valid_reg;
    logic [DUR_W-1:0] in_dur_reg;
    logic             in_start_reg;
    logic             in_end_reg;

    // frame state
    logic [2:0]  phase_reg, phase_next;
    logic [5:0]  bit_idx_reg, bit_idx_next;
    logic [31:0] shift_reg, shift_next;

    // result register
    logic        out_valid_reg;
    logic [1:0]  status_reg, status_next;
    logic [5:0]  count_reg, count_next;
    logic [31:0] value_reg, value_next;
    logic [19:0] addr_reg, addr_next;
    logic [7:0]  cmd_reg, cmd_next;

    logic        advance;
    logic        emit;
    logic        ok;
    logic        done;
    logic [2:0]  cur_phase;
    logic [5:0]  cur_bits;
    logic [31:0] cur_shift;
    logic [5:0]  bits_inc;
    logic [5:0]  nb;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wide_reg   <= 1'b0;
            tol_reg    <= 6'd25;
            excess_reg <= 9'd100;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WIDE_MODE: wide_reg   <= cfg_data[0];
                CFG_TOLERANCE: tol_reg    <= cfg_data[TOL_W-1:0];
                CFG_EXCESS:    excess_reg <= cfg_data[EXC_W-1:0];
                default:       ;
            endcase
        end
    end

    assign win_cfg = '{restart: cfg_we, wide: wide_reg, tol: tol_reg, excess: excess_reg};

    irpd_win_calc u_win_calc (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (win_cfg),
        .busy  (win_busy),
        .lo    (win_lo),
        .hi    (win_hi)
    );

    // pipeline moves when the result slot is free or being emptied
    assign advance       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = !win_busy && !cfg_we && (!in_valid_reg || advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
        else if (advance)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_dur_reg   <= s_axis_tdata;
            in_start_reg <= s_axis_tuser;
            in_end_reg   <= s_axis_tlast;
        end
    end

    // window compares, all six in parallel
    always_comb
    begin
        for (int w = 0; w < NUM_WIN; w++)
            hit[w] = (BOUND_W'(in_dur_reg) >= win_lo[w]) &&
                     (BOUND_W'(in_dur_reg) <= win_hi[w]);
    end

    assign nb = wide_reg ? WIDE_BITS : NARROW_BITS;

    // frame sequencer; a frame start restarts at the header mark
    always_comb
    begin
        cur_phase = in_start_reg ? PH_HDR_MARK : phase_reg;
        cur_bits  = in_start_reg ? 6'd0 : bit_idx_reg;
        cur_shift = in_start_reg ? 32'd0 : shift_reg;
        bits_inc  = cur_bits + 1'b1;

        phase_next   = cur_phase;
        bit_idx_next = cur_bits;
        shift_next   = cur_shift;
        ok           = 1'b1;
        done         = 1'b0;

        case (cur_phase)
            PH_IDLE:
            begin
                ok = 1'b1;
            end
            PH_HDR_MARK:
            begin
                ok         = hit[WIN_HDR_MARK];
                phase_next = PH_HDR_SPC;
            end
            PH_HDR_SPC:
            begin
                ok         = hit[WIN_HDR_SPC];
                phase_next = PH_BIT_MARK;
            end
            PH_BIT_MARK:
            begin
                ok         = hit[WIN_BIT_MARK];
                phase_next = PH_BIT_SPC;
            end
            PH_BIT_SPC:
            begin
                // the one window wins when both match
                if (hit[WIN_ONE_SPC])
                    shift_next = {cur_shift[30:0], 1'b1};
                else if (hit[WIN_ZERO_SPC])
                    shift_next = {cur_shift[30:0], 1'b0};
                else
                    ok = 1'b0;
                bit_idx_next = bits_inc;
                phase_next   = (bits_inc >= nb) ? PH_FT_MARK : PH_BIT_MARK;
            end
            PH_FT_MARK:
            begin
                ok         = hit[WIN_BIT_MARK];
                phase_next = PH_FT_GAP;
            end
            PH_FT_GAP:
            begin
                ok         = hit[WIN_GAP_SPC];
                phase_next = PH_FT_HDR;
            end
            default:
            begin
                ok   = hit[WIN_HDR_MARK];
                done = 1'b1;
            end
        endcase

        emit = (cur_phase != PH_IDLE) && (!ok || done || in_end_reg);

        status_next = !ok ? ST_MISMATCH : (done ? ST_OK : ST_EARLY);
        count_next  = '0;
        value_next  = '0;
        addr_next   = '0;
        cmd_next    = '0;
        if (ok && done)
        begin
            count_next = nb;
            value_next = cur_shift;
            if (wide_reg)
            begin
                addr_next = cur_shift[ADDR_SHIFT +: 20];
                cmd_next  = cur_shift[7:0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            bit_idx_reg   <= '0;
            shift_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= in_valid_reg && emit;
            if (in_valid_reg)
            begin
                if (emit)
                begin
                    phase_reg   <= PH_IDLE;
                    bit_idx_reg <= '0;
                    shift_reg   <= '0;
                end
                else
                begin
                    phase_reg   <= phase_next;
                    bit_idx_reg <= bit_idx_next;
                    shift_reg   <= shift_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && in_valid_reg && emit)
        begin
            status_reg <= status_next;
            count_reg  <= count_next;
            value_reg  <= value_next;
            addr_reg   <= addr_next;
            cmd_reg    <= cmd_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = status_reg;
    assign m_axis_tdata  = {6'd0, cmd_reg, addr_reg, value_reg, count_reg};

    // no transfer is taken while the window bounds are being rebuilt
    a_busy_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        win_busy |-> !s_axis_tready)
        else $error("input taken while window bounds are stale");

    // a config write always starts a new bound sweep
    a_cfg_restarts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_we |=> win_busy)
        else $error("config write did not restart the bound sweep");

    // a decoded frame carries one of the two legal bit counts
    a_ok_bit_count: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == ST_OK) |->
            (m_axis_tdata[5:0] == NARROW_BITS || m_axis_tdata[5:0] == WIDE_BITS))
        else $error("decoded frame with illegal bit count");

    // error results carry an all-zero payload
    a_err_zero_payload: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != ST_OK) |-> (m_axis_tdata == 72'd0))
        else $error("error result with nonzero payload");

endmodule

// ===== test/irpd_checker.sv =====
// Result checker for the infrared frame decoder: predicts from transfers and compares.
`timescale 1ns / 1ps

module irpd_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [irpd_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [irpd_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                            s_axis_tvalid,
    input  logic                            s_axis_tready,
    input  logic [15:0]                     s_axis_tdata,
    input  logic                            s_axis_tuser,
    input  logic                            s_axis_tlast,
    input  logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    input  logic [71:0]                     m_axis_tdata,
    input  logic [1:0]                      m_axis_tuser,
    output int                              mismatches,
    output int                              outstanding,
    output int                              durations_seen,
    output int                              frames_decoded,
    output int                              frames_rejected
);
    import irpd_pkg::*;

    localparam int TOL_AT_RESET    = 25;
    localparam int EXCESS_AT_RESET = 100;
    localparam int REPORT_LIMIT    = 10;

    typedef enum logic [3:0] {
        DEC_IDLE,
        DEC_LEAD_MARK,
        DEC_LEAD_SPACE,
        DEC_DATA_MARK,
        DEC_DATA_SPACE,
        DEC_TRAIL_MARK,
        DEC_TRAIL_GAP,
        DEC_TRAIL_LEAD
    } decode_phase_t;

    typedef struct {
        logic [1:0]  status;
        logic [5:0]  bit_count;
        logic [31:0] value;
        logic [19:0] address;
        logic [7:0]  command;
    } frame_result_t;

    // predictor state and register copies
    decode_phase_t    dec_phase;
    logic [5:0]       bits_done;
    logic [31:0]      bits_shifted;
    logic             wide_cfg;
    logic [TOL_W-1:0] tol_cfg;
    logic [EXC_W-1:0] excess_cfg;

    frame_result_t owed_results[$];

    function automatic bit in_tolerance(int d, int e);
        int lo;
        int hi;
        lo = e * (100 - int'(tol_cfg)) / 100;
        hi = e * (100 + int'(tol_cfg)) / 100 + 1;
        return (d >= lo) && (d <= hi);
    endfunction

    function automatic bit mark_fits(int d, int e);
        return in_tolerance(d, e + int'(excess_cfg));
    endfunction

    // excess shortens spaces, never below zero
    function automatic bit space_fits(int d, int e);
        int x;
        x = int'(excess_cfg);
        return in_tolerance(d, (x > e) ? 0 : e - x);
    endfunction

    function automatic void decode_duration(input logic [15:0] dur, input logic fs,
                                            input logic ce, output bit emitted,
                                            output frame_result_t res);
        int d;
        int hdr_mark;
        int hdr_space;
        int gap;
        int nbits;
        bit ok;
        bit done;
        d         = int'(dur);
        hdr_mark  = wide_cfg ? int'(T_HDR_W) : int'(T_HDR_MARK_N);
        hdr_space = wide_cfg ? int'(T_HDR_W) : int'(T_HDR_SPC_N);
        gap       = wide_cfg ? int'(T_GAP_W) : int'(T_GAP_N);
        nbits     = wide_cfg ? MAX_DATA_BITS_DEF : int'(NARROW_BITS);
        ok        = 1'b1;
        done      = 1'b0;
        emitted   = 1'b0;
        res       = '{default: '0};

        // frame start restarts from any phase
        if (fs)
        begin
            bits_done    = '0;
            bits_shifted = '0;
            dec_phase    = DEC_LEAD_MARK;
        end
        if (dec_phase == DEC_IDLE)
            return;

        case (dec_phase)
            DEC_LEAD_MARK:
            begin
                ok        = mark_fits(d, hdr_mark);
                dec_phase = DEC_LEAD_SPACE;
            end
            DEC_LEAD_SPACE:
            begin
                ok        = space_fits(d, hdr_space);
                dec_phase = DEC_DATA_MARK;
            end
            DEC_DATA_MARK:
            begin
                ok        = mark_fits(d, int'(T_BIT_MARK));
                dec_phase = DEC_DATA_SPACE;
            end
            DEC_DATA_SPACE:
            begin
                // one window has priority when both windows overlap
                if (space_fits(d, int'(T_ONE_SPC)))
                    bits_shifted = {bits_shifted[30:0], 1'b1};
                else if (space_fits(d, int'(T_ZERO_SPC)))
                    bits_shifted = {bits_shifted[30:0], 1'b0};
                else
                    ok = 1'b0;
                bits_done = bits_done + 6'd1;
                dec_phase = (int'(bits_done) >= nbits) ? DEC_TRAIL_MARK : DEC_DATA_MARK;
            end
            DEC_TRAIL_MARK:
            begin
                ok        = mark_fits(d, int'(T_BIT_MARK));
                dec_phase = DEC_TRAIL_GAP;
            end
            DEC_TRAIL_GAP:
            begin
                ok        = space_fits(d, gap);
                dec_phase = DEC_TRAIL_LEAD;
            end
            default:
            begin
                ok   = mark_fits(d, hdr_mark);
                done = 1'b1;
            end
        endcase

        if (!ok || done || ce)
        begin
            emitted    = 1'b1;
            res.status = !ok ? ST_MISMATCH : (done ? ST_OK : ST_EARLY);
            if (ok && done)
            begin
                res.bit_count = 6'(nbits);
                res.value     = bits_shifted;
                if (wide_cfg)
                begin
                    res.address = bits_shifted[31:ADDR_SHIFT];
                    res.command = bits_shifted[7:0];
                end
            end
            dec_phase    = DEC_IDLE;
            bits_done    = '0;
            bits_shifted = '0;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        frame_result_t want;
        frame_result_t fresh;
        bit            emitted;
        logic [5:0]    got_count;
        logic [31:0]   got_value;
        logic [19:0]   got_address;
        logic [7:0]    got_command;
        logic [5:0]    got_pad;
        if (!rst_n)
        begin
            dec_phase       = DEC_IDLE;
            bits_done       = '0;
            bits_shifted    = '0;
            wide_cfg        = 1'b0;
            tol_cfg         = TOL_W'(TOL_AT_RESET);
            excess_cfg      = EXC_W'(EXCESS_AT_RESET);
            mismatches      = 0;
            durations_seen  = 0;
            frames_decoded  = 0;
            frames_rejected = 0;
            owed_results.delete();
        end
        else
        begin
            // results first: whatever leaves now was predicted on an earlier edge
            if (m_axis_tvalid && m_axis_tready)
            begin
                got_count   = m_axis_tdata[5:0];
                got_value   = m_axis_tdata[37:6];
                got_address = m_axis_tdata[57:38];
                got_command = m_axis_tdata[65:58];
                got_pad     = m_axis_tdata[71:66];
                if (owed_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result with none expected: status %0d bits %0d value %h",
                                 $realtime, m_axis_tuser, got_count, got_value);
                end
                else
                begin
                    want = owed_results.pop_front();
                    if (m_axis_tuser !== want.status || got_count !== want.bit_count ||
                        got_value !== want.value || got_address !== want.address ||
                        got_command !== want.command || got_pad !== 6'd0)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"%0t: result mismatch: expected status %0d bits %0d ",
                                      "value %h addr %h cmd %h, got status %0d bits %0d ",
                                      "value %h addr %h cmd %h pad %h"},
                                     $realtime, want.status, want.bit_count, want.value,
                                     want.address, want.command, m_axis_tuser, got_count,
                                     got_value, got_address, got_command, got_pad);
                    end
                    if (want.status == ST_OK)
                        frames_decoded++;
                    else
                        frames_rejected++;
                end
            end

            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_WIDE_MODE: wide_cfg   = cfg_data[0];
                    CFG_TOLERANCE: tol_cfg    = cfg_data[TOL_W-1:0];
                    CFG_EXCESS:    excess_cfg = cfg_data[EXC_W-1:0];
                    default: ;
                endcase
            end

            if (s_axis_tvalid && s_axis_tready)
            begin
                durations_seen++;
                decode_duration(s_axis_tdata, s_axis_tuser, s_axis_tlast, emitted, fresh);
                if (emitted)
                    owed_results.push_back(fresh);
            end
        end
        outstanding <= owed_results.size();
    end

endmodule

// ===== test/testbench.sv =====
// Testbench top for the infrared frame decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module testbench;
    import irpd_pkg::*;

    localparam int ITEM_TARGET    = 450;  // durations before the random part may stop
    localparam int RESULT_TARGET  = 15;   // frames that must end in a result
    localparam int PHASE_ITEMS    = 100;  // durations per register setting
    localparam int HOLD_CYCLES    = 500;  // long receiver hold-off
    localparam int SETTLE_CYCLES  = 8;    // quiet cycles before a register write
    localparam int DRAIN_CYCLES   = 20;   // quiet cycles before the verdict
    localparam int TIMEOUT_NS     = 2000000;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_BAD_DURATION,
        FRAME_CUT_SHORT,
        FRAME_ABANDONED,
        FRAME_NOISE
    } frame_kind_t;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [15:0]           s_axis_tdata;   // [15:0] duration_us
    logic                  s_axis_tuser;   // [0] frame_start
    logic                  s_axis_tlast;   // capture_end
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [71:0]           m_axis_tdata;   // [5:0] count, [37:6] value, [57:38] addr, [65:58] cmd
    logic [1:0]            m_axis_tuser;   // [1:0] status

    int fail_total;
    int results_owed;
    int durations_seen;
    int frames_decoded;
    int frames_rejected;

    // stimulus bookkeeping
    bit   tx_gaps;
    logic rx_gaps;
    logic hold_req;
    bit   hold_served;
    int   items_sent;
    int   result_frames;
    int   settings_applied;
    logic cur_wide;
    int   cur_tol;
    int   cur_excess;

    always #2 clk = ~clk;

    ir_pulse_distance_frame_decoder_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    irpd_checker watcher (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .s_axis_tlast    (s_axis_tlast),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .mismatches      (fail_total),
        .outstanding     (results_owed),
        .durations_seen  (durations_seen),
        .frames_decoded  (frames_decoded),
        .frames_rejected (frames_rejected)
    );

    // Picks a duration inside (hit) or outside the window around nominal e,
    // using the settings last written. Edges of the window get extra weight.
    // above_only keeps a miss above the window, which for a data space also
    // clears the shorter zero window.
    function automatic logic [15:0] pick_duration(int e, bit is_mark, bit hit, bit above_only);
        int c;
        int lo;
        int hi;
        c  = is_mark ? e + cur_excess : ((cur_excess > e) ? 0 : e - cur_excess);
        lo = c * (100 - cur_tol) / 100;
        hi = c * (100 + cur_tol) / 100 + 1;
        if (hi > 65535)
            hi = 65535;
        if (hit)
        begin
            case ($urandom_range(0, 3))
                0: return 16'(lo);
                1: return 16'(hi);
                default: return 16'($urandom_range(hi, lo));
            endcase
        end
        if (hi < 65535 && (above_only || lo == 0 || $urandom_range(0, 1) == 1))
            return 16'($urandom_range(65535, hi + 1));
        return 16'($urandom_range(lo - 1, 0));
    endfunction

    // One duration transfer; optional random gap ahead of it.
    task automatic drive_duration(input logic [15:0] dur, input logic fs, input logic ce);
        if (tx_gaps && $urandom_range(0, 3) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= dur;
        s_axis_tuser  <= fs;
        s_axis_tlast  <= ce;
        do
            @(posedge clk);
        while (!s_axis_tready);
        items_sent++;
    endtask

    // Forces the decoder idle (frame start with capture end always yields a
    // result), drains results, lets the pipeline go quiet, then writes all
    // three registers on consecutive cycles.
    task automatic reconfigure(input logic wide, input int tol, input int excess);
        drive_duration(16'($urandom), 1'b1, 1'b1);
        result_frames++;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_WIDE_MODE;
        cfg_data  <= CFG_DATA_W'(wide);
        @(posedge clk);
        cfg_index <= CFG_TOLERANCE;
        cfg_data  <= CFG_DATA_W'(tol);
        @(posedge clk);
        cfg_index <= CFG_EXCESS;
        cfg_data  <= CFG_DATA_W'(excess);
        @(posedge clk);
        cfg_we     <= 1'b0;
        cur_wide   = wide;
        cur_tol    = tol;
        cur_excess = excess;
        settings_applied++;
    endtask

    // Builds one frame of the given kind with random payload and plays it.
    task automatic play_frame(input frame_kind_t kind);
        int          noms[$];
        bit          is_mk[$];
        bit          is_data[$];
        int          nbits;
        int          hdr_mark;
        int          hdr_space;
        int          gap;
        logic [31:0] payload;
        int          n;
        int          bad_at;
        int          cut_at;
        int          stop_at;
        nbits     = cur_wide ? MAX_DATA_BITS_DEF : int'(NARROW_BITS);
        hdr_mark  = cur_wide ? int'(T_HDR_W) : int'(T_HDR_MARK_N);
        hdr_space = cur_wide ? int'(T_HDR_W) : int'(T_HDR_SPC_N);
        gap       = cur_wide ? int'(T_GAP_W) : int'(T_GAP_N);
        payload   = $urandom;

        if (kind == FRAME_NOISE)
        begin
            // raw junk: random durations, starts and ends
            repeat ($urandom_range(1, 6))
                drive_duration(16'($urandom), $urandom_range(0, 3) == 0,
                               $urandom_range(0, 3) == 0);
            return;
        end

        noms.push_back(hdr_mark);
        is_mk.push_back(1'b1);
        is_data.push_back(1'b0);
        noms.push_back(hdr_space);
        is_mk.push_back(1'b0);
        is_data.push_back(1'b0);
        for (int i = nbits - 1; i >= 0; i--)
        begin
            noms.push_back(int'(T_BIT_MARK));
            is_mk.push_back(1'b1);
            is_data.push_back(1'b0);
            noms.push_back(payload[i] ? int'(T_ONE_SPC) : int'(T_ZERO_SPC));
            is_mk.push_back(1'b0);
            is_data.push_back(1'b1);
        end
        noms.push_back(int'(T_BIT_MARK));
        is_mk.push_back(1'b1);
        is_data.push_back(1'b0);
        noms.push_back(gap);
        is_mk.push_back(1'b0);
        is_data.push_back(1'b0);
        noms.push_back(hdr_mark);
        is_mk.push_back(1'b1);
        is_data.push_back(1'b0);

        n       = noms.size();
        bad_at  = -1;
        cut_at  = -1;
        stop_at = n - 1;
        case (kind)
            FRAME_CLEAN:
            begin
                // capture end on the closing mark still decodes
                if ($urandom_range(0, 1) == 1)
                    cut_at = n - 1;
                result_frames++;
            end
            FRAME_BAD_DURATION:
            begin
                bad_at = $urandom_range(0, n - 1);
                // the tail after a mismatch is ignored by the decoder
                if ($urandom_range(0, 3) != 0)
                    stop_at = bad_at;
                result_frames++;
            end
            FRAME_CUT_SHORT:
            begin
                cut_at = $urandom_range(0, n - 2);
                if ($urandom_range(0, 3) != 0)
                    stop_at = cut_at;
                result_frames++;
            end
            default:
                stop_at = $urandom_range(0, n - 2);   // left hanging; next start restarts
        endcase

        for (int i = 0; i <= stop_at; i++)
            drive_duration(pick_duration(noms[i], is_mk[i], i != bad_at, is_data[i]),
                           i == 0, i == cut_at);
    endtask

    task automatic play_random_frame();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
            play_frame(FRAME_CLEAN);
        else if (roll < 65)
            play_frame(FRAME_BAD_DURATION);
        else if (roll < 80)
            play_frame(FRAME_CUT_SHORT);
        else if (roll < 90)
            play_frame(FRAME_ABANDONED);
        else
            play_frame(FRAME_NOISE);
    endtask

    // Result side: random ready bursts, plus one long hold-off on request.
    initial
    begin
        m_axis_tready <= 1'b0;
        hold_served = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_req && !hold_served)
            begin
                hold_served = 1'b1;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (rx_gaps && $urandom_range(0, 3) == 0)
            begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
    end

    // Watchdog.
    initial
    begin
        #(TIMEOUT_NS);
        $display("ir_pulse_distance_frame_decoder_unit test failed");
        $finish;
    end

    // Stimulus and verdict.
    initial
    begin
        int phase_no;
        int phase_start;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= CFG_WIDE_MODE;
        cfg_data      <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= 1'b0;
        s_axis_tlast  <= 1'b0;
        rx_gaps       <= 1'b1;
        hold_req      <= 1'b0;
        tx_gaps          = 1'b1;
        items_sent       = 0;
        result_frames    = 0;
        settings_applied = 0;
        // register values after reset
        cur_wide   = 1'b0;
        cur_tol    = 25;
        cur_excess = 100;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, reset settings: narrow frame, 25 percent, 100 us excess.
        // Header mark window 6075..10126, header space 2925..4876,
        // bit mark 525..876, one 1125..1876, zero 337..563.
        drive_duration(16'd0, 1'b0, 1'b0);          // idle, ignored
        drive_duration(16'hFFFF, 1'b0, 1'b1);       // idle with capture end, ignored
        drive_duration(16'd8000, 1'b1, 1'b0);
        drive_duration(16'd4000, 1'b0, 1'b0);
        drive_duration(16'hFFFF, 1'b1, 1'b0);       // restart mid-frame, bad header
        drive_duration(16'd0, 1'b1, 1'b0);          // shortest header mark
        drive_duration(16'd8100, 1'b1, 1'b1);       // good header with capture end
        drive_duration(16'd10126, 1'b1, 1'b0);      // window top edge
        drive_duration(16'd2925, 1'b0, 1'b0);       // window bottom edge
        drive_duration(16'd700, 1'b0, 1'b0);
        drive_duration(16'd1600, 1'b0, 1'b1);       // one bit, then capture ends
        drive_duration(16'd6075, 1'b1, 1'b0);
        drive_duration(16'd4000, 1'b0, 1'b0);
        drive_duration(16'd700, 1'b0, 1'b0);
        drive_duration(16'd900, 1'b0, 1'b0);        // between zero and one windows
        drive_duration(16'd6074, 1'b1, 1'b1);       // mismatch wins over capture end
        drive_duration(16'd8000, 1'b1, 1'b0);
        drive_duration(16'd4000, 1'b0, 1'b0);
        drive_duration(16'd600, 1'b0, 1'b0);
        drive_duration(16'd450, 1'b0, 1'b0);        // zero bit
        drive_duration(16'hFFFF, 1'b0, 1'b1);       // bad bit mark

        // Random part: one register setting per phase, extremes first.
        phase_no = 0;
        while (items_sent < ITEM_TARGET || result_frames < RESULT_TARGET)
        begin
            case (phase_no)
                0: reconfigure(1'b0, 0, 0);
                1: reconfigure(1'b1, 50, 500);
                2: reconfigure(1'b1, 63, 511);
                3: reconfigure(1'b0, 63, 0);      // one and zero windows overlap
                4: reconfigure(1'b0, 50, 500);
                default: reconfigure(1'($urandom_range(0, 1)), $urandom_range(0, 63),
                                     $urandom_range(0, 511));
            endcase
            // back pressure: results pile up while durations keep coming
            if (phase_no == 1)
                hold_req <= 1'b1;
            phase_start = items_sent;
            while (items_sent - phase_start < PHASE_ITEMS)
                play_random_frame();
            phase_no++;
        end

        // Closing stretch at full rate on both sides.
        reconfigure(1'($urandom_range(0, 1)), 25, 100);
        tx_gaps = 1'b0;
        rx_gaps <= 1'b0;
        repeat (3) play_frame(FRAME_CLEAN);
        play_frame(FRAME_BAD_DURATION);
        play_frame(FRAME_CUT_SHORT);
        play_frame(FRAME_CLEAN);
        s_axis_tvalid <= 1'b0;

        @(posedge clk);
        while (results_owed != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Covered %0d durations under %0d register settings after reset defaults.",
                 durations_seen, settings_applied);
        $display("Results checked: %0d frames decoded, %0d mismatch or early-end reports.",
                 frames_decoded, frames_rejected);
        if (fail_total == 0 && results_owed == 0)
            $display("ir_pulse_distance_frame_decoder_unit test passed");
        else
            $display("ir_pulse_distance_frame_decoder_unit test failed");
        $finish;
    end

endmodule
